[sv/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

    // Payload field widths
    localparam int CMD_W   = 1;
    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = 11;
    localparam int CELL_W  = 16;
    localparam int OCOL_W  = 7;
    localparam int OROW_W  = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

    // Character codes with special handling
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Tab stops fall on multiples of eight
    localparam int TAB_STEP = 8;

    localparam logic [7:0]        RESET_COLOR = 8'd7;
    localparam logic [CELL_W-1:0] RESET_CELL  = {RESET_COLOR, CH_SPACE};

    // Controller to datapath
    typedef struct packed {
        logic accept;    // item taken this cycle
        logic sweep_en;  // issue one sweep step
        logic clr;       // sweep writes the reset cell
        logic rd_load;   // load result from read data
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_read;   // offered item is a read
        logic scroll;    // offered put item scrolls
        logic ptr_last;  // sweep pointer at last cell
        logic out_valid; // result register full
    } t_dp_sts;

endpackage

`default_nettype wire

[sv/tcw_ctrl.sv]
`default_nettype none

module tcw_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_valid,
    input  wire logic             i_m_ready,
    input  tcw_pkg::t_dp_sts      i_sts,
    output logic                  o_s_ready,
    output tcw_pkg::t_dp_cmd      o_cmd
);
    import tcw_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Take an item only when idle and the result register is free or being taken
    assign o_s_ready = (r_state == ST_IDLE) && (!i_sts.out_valid || i_m_ready);

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.accept   = i_s_valid && o_s_ready;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.sweep_en = 1'b1;
                o_cmd.clr      = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_IDLE: begin
                if (o_cmd.accept) begin
                    if (i_sts.is_read) begin
                        n_state = ST_READ;
                    end else if (i_sts.scroll) begin
                        n_state = ST_SWEEP;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_load = 1'b1;
                n_state       = ST_IDLE;
            end
            ST_SWEEP: begin
                o_cmd.sweep_en = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[sv/tcw_datapath.sv]
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  tcw_pkg::t_dp_cmd                  i_cmd,
    output tcw_pkg::t_dp_sts                  o_sts,
    input  wire logic [tcw_pkg::CMD_W-1:0]    i_item_cmd,
    input  wire logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic [tcw_pkg::ADDR_W-1:0]   i_cell_addr,
    input  wire logic                         i_cfg_we,
    input  wire logic [7:0]                   i_cfg_data,
    input  wire logic                         i_m_ready,
    output logic                              o_out_valid,
    output logic [tcw_pkg::CELL_W-1:0]        o_cell_data,
    output logic [tcw_pkg::OCOL_W-1:0]        o_cursor_col,
    output logic [tcw_pkg::OROW_W-1:0]        o_cursor_row,
    output logic                              o_scrolled
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int AW     = $clog2(CELLS);
    localparam int CW     = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);
    localparam int EW     = (AW > ADDR_W) ? AW : ADDR_W;
    localparam int COPY_N = (ROWS - 1) * COLUMNS;

    localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
    localparam logic [AW-1:0] COPY_A   = AW'(COPY_N);
    localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
    localparam logic [CW:0]   COLS_X   = (CW + 1)'(COLUMNS);
    localparam logic [CW:0]   TAB_X    = (CW + 1)'(TAB_STEP);
    localparam logic [CW:0]   TAB_MASK = ~((CW + 1)'(TAB_STEP - 1));
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    logic [CELL_W-1:0] mem [CELLS];

    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [7:0]        r_color;
    logic [7:0]        r_battr;
    logic [AW-1:0]     r_ptr;
    logic              r_wv;
    logic [AW-1:0]     r_wa;
    logic              r_wcopy;
    logic              r_wclr;
    logic [CELL_W-1:0] r_rdata;
    logic              r_rd_ok;

    logic [CW-1:0]     n_col;
    logic [RW-1:0]     n_row;
    logic              put_item;
    logic              put_wr;
    logic              nl;
    logic              scr;
    logic [CW-1:0]     wcol;
    logic [CHAR_W-1:0] wchar;
    logic [CW:0]       col_inc;
    logic [CW:0]       col_tab;
    logic [AW-1:0]     w_addr;
    logic [AW-1:0]     rd_addr;
    logic [EW-1:0]     addr_ext;
    logic              rd_ok;
    logic              copy_step;
    logic              put_we;
    logic              load_put;
    logic [CELL_W-1:0] sweep_cell;

    assign put_item = (i_item_cmd == CMD_PUT);
    assign col_inc  = {1'b0, r_col} + 1'b1;
    assign col_tab  = ({1'b0, r_col} + TAB_X) & TAB_MASK;

    // Cursor update for a put item
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        wcol   = r_col;
        wchar  = i_char_code;
        put_wr = 1'b0;
        nl     = 1'b0;
        scr    = 1'b0;
        unique case (i_char_code)
            CH_BS: begin
                // erased cell becomes a blank
                wchar = CH_SPACE;
                if (r_col != '0) begin
                    n_col  = r_col - 1'b1;
                    wcol   = r_col - 1'b1;
                    put_wr = 1'b1;
                end
            end
            CH_TAB: begin
                if (col_tab >= COLS_X) begin
                    nl = 1'b1;
                end else begin
                    n_col = col_tab[CW-1:0];
                end
            end
            CH_LF: begin
                nl = 1'b1;
            end
            CH_CR: begin
                n_col = '0;
            end
            default: begin
                put_wr = 1'b1;
                if (col_inc >= COLS_X) begin
                    nl = 1'b1;
                end else begin
                    n_col = col_inc[CW-1:0];
                end
            end
        endcase
        // Next line, scrolling from the bottom row
        if (nl) begin
            n_col = '0;
            if (r_row == LAST_ROW) begin
                scr = 1'b1;
            end else begin
                n_row = r_row + 1'b1;
            end
        end
    end

    assign w_addr   = AW'(r_row) * COLS_A + AW'(wcol);
    assign put_we   = i_cmd.accept && put_item && put_wr;
    assign load_put = i_cmd.accept && put_item;

    // Read address: sweep source or item cell
    assign addr_ext  = EW'(i_cell_addr);
    assign rd_ok     = (32'(i_cell_addr) < CELLS);
    assign copy_step = !i_cmd.clr && (r_ptr < COPY_A);
    always_comb begin
        if (i_cmd.sweep_en) begin
            rd_addr = copy_step ? (r_ptr + COLS_A) : r_ptr;
        end else begin
            rd_addr = rd_ok ? addr_ext[AW-1:0] : '0;
        end
    end

    assign sweep_cell = r_wclr ? RESET_CELL : {r_battr, CH_SPACE};

    // Screen store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_wv) begin
            mem[r_wa] <= r_wcopy ? r_rdata : sweep_cell;
        end else if (put_we) begin
            mem[w_addr] <= {r_color, wchar};
        end
        r_rdata <= mem[rd_addr];
    end

    // Sweep pointer and delayed write stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_wv  <= 1'b0;
        end else begin
            r_wv <= i_cmd.sweep_en;
            if (i_cmd.sweep_en) begin
                r_ptr <= (r_ptr == LAST_A) ? '0 : r_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa    <= r_ptr;
        r_wcopy <= copy_step;
        r_wclr  <= i_cmd.clr;
        r_rd_ok <= rd_ok;
        if (i_cmd.accept) begin
            r_battr <= r_color;
        end
    end

    // Cursor and text color
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_color <= RESET_COLOR;
        end else begin
            if (load_put) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cfg_we) begin
                r_color <= i_cfg_data;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (load_put || i_cmd.rd_load) begin
            o_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_put) begin
            o_cell_data  <= '0;
            o_cursor_col <= OCOL_W'(n_col);
            o_cursor_row <= OROW_W'(n_row);
            o_scrolled   <= scr;
        end else if (i_cmd.rd_load) begin
            o_cell_data  <= r_rd_ok ? r_rdata : '0;
            o_cursor_col <= OCOL_W'(r_col);
            o_cursor_row <= OROW_W'(r_row);
            o_scrolled   <= 1'b0;
        end
    end

    // Status to controller
    always_comb begin
        o_sts           = '0;
        o_sts.is_read   = (i_item_cmd == CMD_READ);
        o_sts.scroll    = put_item && scr;
        o_sts.ptr_last  = (r_ptr == LAST_A);
        o_sts.out_valid = o_out_valid;
    end

    // Sweep writes and item writes never share the port
    a_wr_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wv && put_we))
        else $error("sweep write collides with item write");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < COLUMNS)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < ROWS)
        else $error("cursor row out of range");

    a_scroll_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && o_sts.scroll) |=> (i_cmd.sweep_en && r_ptr == '0))
        else $error("scrolling item did not start a sweep");

endmodule

`default_nettype wire

[sv/text_console_writer.sv]
// Text-mode console writer: streams character bytes into a COLUMNS x ROWS
// screen store of 16-bit cells (attribute high byte, character low byte)
// and returns one result per item with the cursor after it. A put that does
// not scroll is taken while idle and loads the result register, so such
// items go at one per cycle while results are taken. A read passes through
// a read state that loads the result from the registered store read.
// A put that scrolls copies every row up and blanks the bottom row through
// the store's single read and single write port, one cell per cycle. After
// reset a clearing pass writes a space with attribute 7 to every cell,
// during which no item is taken; text_color writes are taken at any time
// and always ready.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // char_code[7:0], cell_addr[18:8], zero
    input  wire logic [0:0]  s_axis_tuser,  // cmd[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // cell_data[15:0], cursor_col[22:16],
                                            // cursor_row[27:23], scrolled[28], zero
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data     // text_color
);
    import tcw_pkg::*;

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [CELL_W-1:0] cell_data;
    logic [OCOL_W-1:0] cursor_col;
    logic [OROW_W-1:0] cursor_row;
    logic              scrolled;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    tcw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_sts     (sts),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd)
    );

    // Store, cursor and result register
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_item_cmd   (s_axis_tuser[0]),
        .i_char_code  (s_axis_tdata[7:0]),
        .i_cell_addr  (s_axis_tdata[18:8]),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_m_ready    (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_cell_data  (cell_data),
        .o_cursor_col (cursor_col),
        .o_cursor_row (cursor_row),
        .o_scrolled   (scrolled)
    );

    // Result packing
    assign m_axis_tdata = {3'b000, scrolled, cursor_row, cursor_col, cell_data};

endmodule

`default_nettype wire
